/* rtl/rgc_pkg.sv */
`default_nettype none

package rgc_pkg;

    // Timing constants
    localparam logic [8:0]  WARMUP_COUNT    = 9'd401;
    localparam logic [3:0]  WARMUP_STEP_MS  = 4'd10;
    localparam logic [19:0] SAFETY_LIMIT_MS = 20'd30000;
    localparam logic [3:0]  ON_TIME_UNIT    = 4'd10;
    localparam logic [19:0] ELAPSED_MAX     = 20'hFFFFF;

    // Item kinds
    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_START    = 3'd1,
        KIND_RELEASE  = 3'd2,
        KIND_SEEK     = 3'd3,
        KIND_RESET    = 3'd4,
        KIND_RAISE_OT = 3'd5
    } kind_t;

    // Run sources
    localparam logic [2:0] SRC_IDLE   = 3'd0;
    localparam logic [2:0] SRC_TOUCH  = 3'd1;
    localparam logic [2:0] SRC_COMM   = 3'd2;
    localparam logic [2:0] SRC_REMOTE = 3'd3;
    localparam logic [2:0] SRC_CYCLE  = 3'd4;

    // Energy outcomes
    localparam logic [1:0] OUTCOME_CONTINUE = 2'd0;
    localparam logic [1:0] OUTCOME_FAULT    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENERGY_MODE   = 2'd0;
    localparam logic [1:0] CFG_HAND_MODEL    = 2'd1;
    localparam logic [1:0] CFG_ON_TIME_LIMIT = 2'd2;

    typedef struct packed {
        logic        energy_mode;
        logic        hand_model;
        logic [15:0] on_time_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  run_code;
        logic        warmup_active;
        logic [8:0]  warmup_steps;
        logic [3:0]  cadence_ms;
        logic [19:0] run_elapsed;
        logic        swallow_flag;
        logic        overtime_latch;
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] source;
        logic       seek_reset_busy;
        logic       overload_flag;
        logic       estop_flag;
        logic       horn_flag;
        logic [1:0] energy_outcome;
    } item_t;

    typedef struct packed {
        logic [2:0] run_source;
        logic       warming;
        logic       fault_overtime;
        logic       drive_enable;
        logic       can_start;
        logic       stop_pulse;
        logic       swallow_pending;
    } result_t;

endpackage

`default_nettype wire

/* rtl/rgc_in_if.sv */
`default_nettype none

interface rgc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] src;
    logic       seek_reset_busy;
    logic       overload_flag;
    logic       estop_flag;
    logic       horn_flag;
    logic [1:0] energy_outcome;

    modport source (
        output valid, kind, src, seek_reset_busy, overload_flag, estop_flag,
               horn_flag, energy_outcome,
        input  ready
    );

    modport sink (
        input  valid, kind, src, seek_reset_busy, overload_flag, estop_flag,
               horn_flag, energy_outcome,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/rgc_out_if.sv */
`default_nettype none

interface rgc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] run_source;
    logic       warming;
    logic       fault_overtime;
    logic       drive_enable;
    logic       can_start;
    logic       stop_pulse;
    logic       swallow_pending;

    modport source (
        output valid, run_source, warming, fault_overtime, drive_enable, can_start,
               stop_pulse, swallow_pending,
        input  ready
    );

    modport sink (
        input  valid, run_source, warming, fault_overtime, drive_enable, can_start,
               stop_pulse, swallow_pending,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/run_gate_controller.sv */
`default_nettype none

// Run gate for an ultrasonic output stage.
//
// cmd    : input beats, one per 1 ms tick or command (start, release, seek,
//          reset, raise overtime) with the blocking flags and energy outcome.
// status : one result beat per cmd beat, in order: run source, warm-up,
//          fault latch, drive enable, start permission, stop pulse, swallow.
// cfg    : write port (cfg_we, cfg_index, cfg_data); write only while idle.
//
// A cmd beat that is accepted lands in the input register; its result is then
// registered in the result register and shown from there.
// Throughput: one beat per cycle while status is taken; the state update
// is a single pass of short logic between the input and result registers.
// Stall: when status is not taken, the result register holds, the input
// register holds one more beat, and cmd.ready drops only when both are full.
// Reset: run idle, warm-up armed (401 steps of 10 ms), fault and swallow
// clear, configuration zero, both pipeline stages empty.
module run_gate_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rgc_in_if.sink           cmd,
    rgc_out_if.source        status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    rgc_pkg::cfg_t    cfg_reg;
    rgc_pkg::state_t  st_reg;
    rgc_pkg::state_t  st_next;
    rgc_pkg::item_t   item_reg;
    rgc_pkg::item_t   item_in;
    rgc_pkg::result_t res_next;
    rgc_pkg::result_t res_reg;
    logic             item_valid_reg;
    logic             res_valid_reg;
    logic             advance;
    logic             cmd_accept;

    // Move the input stage forward when the result slot is free or being drained.
    assign advance    = item_valid_reg && (!res_valid_reg || status.ready);
    assign cmd.ready  = !item_valid_reg || advance;
    assign cmd_accept = cmd.valid && cmd.ready;

    assign item_in.kind            = cmd.kind;
    assign item_in.source          = cmd.src;
    assign item_in.seek_reset_busy = cmd.seek_reset_busy;
    assign item_in.overload_flag   = cmd.overload_flag;
    assign item_in.estop_flag      = cmd.estop_flag;
    assign item_in.horn_flag       = cmd.horn_flag;
    assign item_in.energy_outcome  = cmd.energy_outcome;

    rgc_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgc_pkg::CFG_ENERGY_MODE:   cfg_reg.energy_mode   <= cfg_data[0];
                rgc_pkg::CFG_HAND_MODEL:    cfg_reg.hand_model    <= cfg_data[0];
                rgc_pkg::CFG_ON_TIME_LIMIT: cfg_reg.on_time_limit <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Control state: stage valids and the gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg         <= '{run_code:       rgc_pkg::SRC_IDLE,
                                warmup_active:  1'b1,
                                warmup_steps:   9'd0,
                                cadence_ms:     4'd0,
                                run_elapsed:    20'd0,
                                swallow_flag:   1'b0,
                                overtime_latch: 1'b0};
        end
        else
        begin
            if (cmd_accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (status.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload: hold input beat and result while stalled
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_next;
    end

    assign status.valid           = res_valid_reg;
    assign status.run_source      = res_reg.run_source;
    assign status.warming         = res_reg.warming;
    assign status.fault_overtime  = res_reg.fault_overtime;
    assign status.drive_enable    = res_reg.drive_enable;
    assign status.can_start       = res_reg.can_start;
    assign status.stop_pulse      = res_reg.stop_pulse;
    assign status.swallow_pending = res_reg.swallow_pending;

endmodule

`default_nettype wire

/* rtl/rgc_step.sv */
`default_nettype none

// Next state and result for one beat.
module rgc_step (
    input  var rgc_pkg::state_t  st,
    input  var rgc_pkg::cfg_t    cfg,
    input  var rgc_pkg::item_t   item,
    output rgc_pkg::state_t      st_next,
    output rgc_pkg::result_t     res
);

    logic [19:0] limit_ms;
    logic        blocked;

    assign limit_ms = 20'(cfg.on_time_limit) * 20'(rgc_pkg::ON_TIME_UNIT);
    assign blocked  = item.seek_reset_busy | item.overload_flag | item.estop_flag
                    | item.horn_flag;

    always_comb
    begin
        rgc_pkg::state_t n;
        logic            stop;
        logic            auto_stop;

        n         = st;
        stop      = 1'b0;
        auto_stop = 1'b0;

        case (rgc_pkg::kind_t'(item.kind))
            rgc_pkg::KIND_TICK:
            begin
                n.cadence_ms = st.cadence_ms + 4'd1;
                if (n.cadence_ms >= rgc_pkg::WARMUP_STEP_MS)
                begin
                    n.cadence_ms = 4'd0;
                    if (st.warmup_active)
                    begin
                        n.warmup_steps = st.warmup_steps + 9'd1;
                        if (n.warmup_steps >= rgc_pkg::WARMUP_COUNT)
                            n.warmup_active = 1'b0;
                    end
                end
                if (st.run_code != rgc_pkg::SRC_IDLE)
                begin
                    if (st.run_elapsed != rgc_pkg::ELAPSED_MAX)
                        n.run_elapsed = st.run_elapsed + 20'd1;
                    if (n.run_elapsed >= rgc_pkg::SAFETY_LIMIT_MS)
                        auto_stop = 1'b1;
                    else if (st.run_code != rgc_pkg::SRC_CYCLE)
                    begin
                        if (cfg.energy_mode)
                        begin
                            if (item.energy_outcome != rgc_pkg::OUTCOME_CONTINUE)
                                auto_stop = 1'b1;
                            if (item.energy_outcome == rgc_pkg::OUTCOME_FAULT)
                                n.overtime_latch = 1'b1;
                        end
                        else if (cfg.hand_model && cfg.on_time_limit != 16'd0 &&
                                 (st.run_code == rgc_pkg::SRC_COMM ||
                                  st.run_code == rgc_pkg::SRC_REMOTE) &&
                                 n.run_elapsed >= limit_ms)
                            auto_stop = 1'b1;
                    end
                end
                if (auto_stop)
                begin
                    // an auto-stopped touch run swallows the next touch start or touch release
                    if (st.run_code == rgc_pkg::SRC_TOUCH)
                        n.swallow_flag = 1'b1;
                    n.run_code = rgc_pkg::SRC_IDLE;
                    stop       = 1'b1;
                end
            end
            rgc_pkg::KIND_START:
            begin
                if (!st.warmup_active && st.run_code == rgc_pkg::SRC_IDLE)
                begin
                    if (item.source == rgc_pkg::SRC_TOUCH && st.swallow_flag)
                        n.swallow_flag = 1'b0;
                    else if (!blocked && !st.overtime_latch &&
                             item.source >= rgc_pkg::SRC_TOUCH &&
                             item.source <= rgc_pkg::SRC_CYCLE)
                    begin
                        n.run_code    = item.source;
                        n.run_elapsed = 20'd0;
                    end
                end
            end
            rgc_pkg::KIND_RELEASE:
            begin
                if (st.run_code != rgc_pkg::SRC_IDLE)
                begin
                    n.run_code = rgc_pkg::SRC_IDLE;
                    stop       = 1'b1;
                end
                else if (item.source == rgc_pkg::SRC_TOUCH && st.swallow_flag)
                    n.swallow_flag = 1'b0;
            end
            rgc_pkg::KIND_RESET:
                n.overtime_latch = 1'b0;
            rgc_pkg::KIND_RAISE_OT:
                n.overtime_latch = 1'b1;
            default:
                ;
        endcase

        st_next             = n;
        res.run_source      = n.run_code;
        res.warming         = n.warmup_active;
        res.fault_overtime  = n.overtime_latch;
        res.drive_enable    = (n.run_code != rgc_pkg::SRC_IDLE);
        res.can_start       = !n.warmup_active && n.run_code == rgc_pkg::SRC_IDLE &&
                              !blocked && !n.overtime_latch;
        res.stop_pulse      = stop;
        res.swallow_pending = n.swallow_flag;
    end

endmodule

`default_nettype wire

/* rtl/rgc_checker.sv */
`default_nettype none

module rgc_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       valid,
    input  wire logic       ready,
    input  wire logic [2:0] run_source,
    input  wire logic       warming,
    input  wire logic       fault_overtime,
    input  wire logic       drive_enable,
    input  wire logic       can_start,
    input  wire logic       stop_pulse
);

    // A stalled result beat stays valid and holds its run source, start permission and stop pulse.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(run_source) && $stable(can_start)
                            && $stable(stop_pulse))
        else $error("status beat changed while stalled");

    a_drive: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> drive_enable == (run_source != rgc_pkg::SRC_IDLE))
        else $error("drive_enable disagrees with run_source");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        valid && can_start |-> !warming && !fault_overtime
                               && run_source == rgc_pkg::SRC_IDLE)
        else $error("can_start while gated");

    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        valid && stop_pulse |-> !drive_enable)
        else $error("stop pulse with the drive still on");

endmodule

bind run_gate_controller rgc_checker u_rgc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (status.valid),
    .ready          (status.ready),
    .run_source     (status.run_source),
    .warming        (status.warming),
    .fault_overtime (status.fault_overtime),
    .drive_enable   (status.drive_enable),
    .can_start      (status.can_start),
    .stop_pulse     (status.stop_pulse)
);

`default_nettype wire
